// File: hdl/wlv_pkg.sv
// Shared constants, types and helper functions of the windowed local variance block.
`default_nettype none
package wlv_pkg;

   // Window and frame geometry.
   localparam int WINDOW     = 5;
   localparam int HALF       = WINDOW / 2;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int DEPTH      = WINDOW * MAX_WIDTH;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int IDX_W      = COL_W + ROW_W;
   localparam int TOT_W      = IDX_W + 1;
   localparam int W_W        = 11;
   localparam int H_W        = 13;
   localparam int HALF_W     = $clog2(HALF + 1);
   localparam int SPAN_W     = $clog2(WINDOW + 1);
   localparam int CNT_W      = $clog2(WINDOW * WINDOW + 1);

   // Arithmetic widths.
   localparam int PIX_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int TERM_W     = 2 * PIX_W - 1 - FRAC_W;
   localparam int SUM_W      = PIX_W + CNT_W;
   localparam int SQ_W       = TERM_W + CNT_W;
   localparam int DIV_W      = SQ_W;
   localparam int STEP_W     = $clog2(DIV_W);

   // Request queue between front and back.
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);

   // Register port.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = CSR_IDX_W'(1);

   // Request kinds.
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // One window job handed from front to back.
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [ADDR_W-1:0] addr;
      logic              last;
   } cmd_type;

   // Frame size in use.
   typedef struct packed {
      logic [W_W-1:0] width;
      logic [H_W-1:0] height;
   } frame_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_SETUP, BK_SCAN, BK_FLUSH, BK_DIV_SQ, BK_DIV_SUM, BK_SQUARE, BK_DONE
   } back_state_type;

   // Width register value as used: zero acts as one, large values saturate.
   function automatic logic [W_W-1:0] clamp_width(input logic [W_W-1:0] v);
      logic [W_W-1:0] r;
      r = v;
      if (v == '0) r = W_W'(1);
      else if (v > W_W'(MAX_WIDTH)) r = W_W'(MAX_WIDTH);
      return r;
   endfunction

   function automatic logic [H_W-1:0] clamp_height(input logic [H_W-1:0] v);
      logic [H_W-1:0] r;
      r = v;
      if (v == '0) r = H_W'(1);
      else if (v > H_W'(MAX_HEIGHT)) r = H_W'(MAX_HEIGHT);
      return r;
   endfunction

   // Store address plus one, wrapping at the store depth.
   function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      r = a + 1'b1;
      if (a == ADDR_W'(DEPTH - 1)) r = '0;
      return r;
   endfunction

   // Store address plus a row width, wrapping at the store depth.
   function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
                                                  input logic [W_W-1:0] w);
      logic [ADDR_W:0] s;
      s = (ADDR_W + 1)'(a) + (ADDR_W + 1)'(w);
      if (s >= (ADDR_W + 1)'(DEPTH)) s = s - (ADDR_W + 1)'(DEPTH);
      return s[ADDR_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: hdl/windowed_local_variance.sv
// Top level of the windowed local variance block.
//
//   Channel  Direction  Handshake              Contents
//   req      in         req_valid / req_stall  req_type, req_pixel_value
//   rsp      out        rsp_valid / rsp_stall  rsp_variance, rsp_frame_last
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// A request that makes no result queues no window job. A request that makes a result
// queues a window job; the back end takes the job, sets up the window, reads the window
// through the single read port of the line store, empties the read pipeline, runs the
// one-bit-a-step divider twice, once on the sum of squares and once on the sum, squares
// the mean and loads the result register, which it does only once the previous result
// has left; it takes no new job until then. The job queue holds four jobs ahead.
// Reset is synchronous; the line store is not cleared, since no read reaches an entry
// that the current frame has not written. The first pixel of a frame waits until all
// jobs of the previous frame have finished. The csr port is always ready.
`default_nettype none
module windowed_local_variance import wlv_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_type,
   input  wire logic [PIX_W-1:0]      req_pixel_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [PIX_W-1:0]           rsp_variance,
   output logic                       rsp_frame_last,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type           push_cmd, head_cmd;
   frame_type         frame;
   logic              q_push, q_pop, q_full, q_empty, back_idle;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [PIX_W-1:0]  wr_data, rd_data;

   assign csr_ready = 1'b1;

   // Intake and job issue.
   wlv_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_type        (req_type),
      .req_pixel_value (req_pixel_value),
      .req_stall       (req_stall),
      .q_full          (q_full),
      .back_idle       (back_idle),
      .q_push          (q_push),
      .q_cmd           (push_cmd),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .frame           (frame)
   );

   // Job queue.
   wlv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head     (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Line store.
   wlv_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Window evaluation.
   wlv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .frame          (frame),
      .q_empty        (q_empty),
      .q_head         (head_cmd),
      .q_pop          (q_pop),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .back_idle      (back_idle),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_variance   (rsp_variance),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
`default_nettype wire

// File: hdl/wlv_store.sv
// Line store: the most recent pixels, one write port and one registered read port.
`default_nettype none
module wlv_store import wlv_pkg::*; (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [PIX_W-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [PIX_W-1:0]  rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: hdl/wlv_queue.sv
// Short queue of window jobs between the front and the back.
`default_nettype none
module wlv_queue import wlv_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         full,
   output logic         empty
);

   cmd_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;

   assign head  = slot_ff[rd_ptr_ff];
   assign full  = (fill_ff == (QPTR_W + 1)'(QDEPTH));
   assign empty = (fill_ff == '0);

   // Pointer and fill updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule
`default_nettype wire

// File: hdl/wlv_front.sv
// Front end: frame registers, pixel intake into the line store and window job issue.
`default_nettype none
module wlv_front import wlv_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  req_valid,
   input  wire logic                  req_type,
   input  wire logic [PIX_W-1:0]      req_pixel_value,
   output logic                       req_stall,
   input  wire logic                  q_full,
   input  wire logic                  back_idle,
   output logic                       q_push,
   output cmd_type                    q_cmd,
   output logic                       wr_en,
   output logic [ADDR_W-1:0]          wr_addr,
   output logic [PIX_W-1:0]           wr_data,
   output frame_type                  frame
);

   logic [W_W-1:0]    width_ff, width_in;
   logic [H_W-1:0]    height_ff, height_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W-1:0]  lag_ff, lag_in;
   logic              frame_in_ff, frame_in_in;
   logic [IDX_W-1:0]  in_idx_ff, in_idx_in;
   logic [ADDR_W-1:0] in_addr_ff, in_addr_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;

   logic           accept, take_pixel, emit, out_last, csr_write;
   logic [W_W-1:0] new_width;
   logic [H_W-1:0] new_height;

   // A new frame waits until the back has finished every job of the previous one,
   // so that its first pixels cannot overwrite entries still to be read.
   assign req_stall  = q_full || (!frame_in_ff && (in_idx_ff == '0) && !back_idle);
   assign accept     = req_valid && !req_stall;
   assign take_pixel = accept && (req_type == REQ_PIXEL) && !frame_in_ff;
   assign out_last   = (TOT_W'(out_idx_ff) + 1'b1 >= total_ff);
   assign emit       = take_pixel ? (TOT_W'(out_idx_ff) + lag_ff <= TOT_W'(in_idx_ff))
                                  : (accept && frame_in_ff);
   assign csr_write  = csr_valid && ((csr_index == REG_WIDTH) || (csr_index == REG_HEIGHT));
   assign new_width  = clamp_width(csr_data[W_W-1:0]);
   assign new_height = clamp_height(csr_data[H_W-1:0]);

   assign wr_en   = take_pixel;
   assign wr_addr = in_addr_ff;
   assign wr_data = req_pixel_value;

   assign q_push = emit;
   assign q_cmd  = '{row: out_row_ff, col: out_col_ff, addr: out_addr_ff, last: out_last};

   assign frame = '{width: width_ff, height: height_ff};

   // Next state of the frame counters.
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      total_in    = total_ff;
      lag_in      = lag_ff;
      frame_in_in = frame_in_ff;
      in_idx_in   = in_idx_ff;
      in_addr_in  = in_addr_ff;
      out_idx_in  = out_idx_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_addr_in = out_addr_ff;

      // Pixel intake.
      if (take_pixel) begin
         if (TOT_W'(in_idx_ff) + 1'b1 >= total_ff) begin
            in_idx_in   = '0;
            in_addr_in  = '0;
            frame_in_in = 1'b1;
         end else begin
            in_idx_in  = in_idx_ff + 1'b1;
            in_addr_in = addr_inc(in_addr_ff);
         end
      end

      // Result position advance.
      if (emit) begin
         if (out_last) begin
            out_idx_in  = '0;
            out_row_in  = '0;
            out_col_in  = '0;
            out_addr_in = '0;
            frame_in_in = 1'b0;
         end else begin
            out_idx_in  = out_idx_ff + 1'b1;
            out_addr_in = addr_inc(out_addr_ff);
            if (W_W'(out_col_ff) + 1'b1 >= width_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end

      // A register write restarts the frame.
      if (csr_write) begin
         if (csr_index == REG_WIDTH) begin
            width_in = new_width;
            total_in = TOT_W'(new_width) * TOT_W'(height_ff);
            lag_in   = TOT_W'(HALF) * TOT_W'(new_width) + TOT_W'(HALF);
         end else begin
            height_in = new_height;
            total_in  = TOT_W'(width_ff) * TOT_W'(new_height);
         end
         frame_in_in = 1'b0;
         in_idx_in   = '0;
         in_addr_in  = '0;
         out_idx_in  = '0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= W_W'(1024);
         height_ff   <= H_W'(1024);
         total_ff    <= TOT_W'(1024 * 1024);
         lag_ff      <= TOT_W'(HALF * 1024 + HALF);
         frame_in_ff <= 1'b0;
         in_idx_ff   <= '0;
         in_addr_ff  <= '0;
         out_idx_ff  <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_addr_ff <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         total_ff    <= total_in;
         lag_ff      <= lag_in;
         frame_in_ff <= frame_in_in;
         in_idx_ff   <= in_idx_in;
         in_addr_ff  <= in_addr_in;
         out_idx_ff  <= out_idx_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         out_addr_ff <= out_addr_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/wlv_back.sv
// Back end: window scan over the line store, accumulation, serial division and result register.
`default_nettype none
module wlv_back import wlv_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire frame_type         frame,
   input  wire logic              q_empty,
   input  wire cmd_type           q_head,
   output logic                   q_pop,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   input  wire logic [PIX_W-1:0]  rd_data,
   output logic                   back_idle,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output logic [PIX_W-1:0]       rsp_variance,
   output logic                   rsp_frame_last
);

   back_state_type state_ff, state_in;

   cmd_type             cmd_ff;
   logic [ADDR_W-1:0]   row_addr_ff, row_addr_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [SPAN_W-1:0]   ny_ff, nx_ff, ry_ff, ry_in, cx_ff, cx_in;
   logic [CNT_W-1:0]    count_ff;
   logic                v1_ff, v2_ff;
   logic [PIX_W-1:0]    val2_ff;
   logic signed [2*PIX_W-1:0] sq2_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic [SQ_W-1:0]     sumsq_ff;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [PIX_W-1:0]    qsq_ff;
   logic                neg_ff;
   logic signed [PIX_W-1:0]   mean_ff;
   logic signed [2*PIX_W-1:0] mm_ff;
   logic                rsp_valid_ff;
   logic [PIX_W-1:0]    rsp_variance_ff;
   logic                rsp_frame_last_ff;

   // Window geometry of the job just taken.
   logic [HALF_W-1:0]   dy, dx;
   logic [H_W:0]        y_lo, y_hi;
   logic [W_W:0]        x_lo, x_hi;
   logic [SPAN_W-1:0]   ny_calc, nx_calc;
   logic [ADDR_W+1:0]   base_raw;
   logic [ADDR_W-1:0]   base;
   logic [HALF_W+W_W-1:0] dyw;

   // Serial divider step.
   logic [CNT_W:0]      rem_shift;
   logic                rem_ge;
   logic [CNT_W-1:0]    rem_next;
   logic [DIV_W-1:0]    div_next;
   logic [SUM_W-1:0]    sum_mag;

   logic                cx_last, ry_last, div_done, out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_variance   = rsp_variance_ff;
   assign rsp_frame_last = rsp_frame_last_ff;
   assign back_idle      = (state_ff == BK_IDLE) && q_empty;
   assign out_free       = !rsp_valid_ff;

   // Clipped window bounds around the result position.
   always_comb begin
      dy = (cmd_ff.row >= ROW_W'(HALF)) ? HALF_W'(HALF) : HALF_W'(cmd_ff.row);
      dx = (cmd_ff.col >= COL_W'(HALF)) ? HALF_W'(HALF) : HALF_W'(cmd_ff.col);
      y_lo = (H_W + 1)'(cmd_ff.row) - (H_W + 1)'(dy);
      y_hi = (H_W + 1)'(cmd_ff.row) + (H_W + 1)'(HALF);
      if (y_hi >= (H_W + 1)'(frame.height)) y_hi = (H_W + 1)'(frame.height) - 1'b1;
      x_lo = (W_W + 1)'(cmd_ff.col) - (W_W + 1)'(dx);
      x_hi = (W_W + 1)'(cmd_ff.col) + (W_W + 1)'(HALF);
      if (x_hi >= (W_W + 1)'(frame.width)) x_hi = (W_W + 1)'(frame.width) - 1'b1;
      ny_calc  = SPAN_W'(y_hi - y_lo + 1'b1);
      nx_calc  = SPAN_W'(x_hi - x_lo + 1'b1);
      dyw      = (HALF_W + W_W)'(dy) * (HALF_W + W_W)'(frame.width);
      base_raw = (ADDR_W + 2)'(cmd_ff.addr) - (ADDR_W + 2)'(dyw) - (ADDR_W + 2)'(dx);
      if (base_raw[ADDR_W+1]) base_raw = base_raw + (ADDR_W + 2)'(DEPTH);
      base = base_raw[ADDR_W-1:0];
   end

   // One restoring division step per cycle.
   always_comb begin
      rem_shift = {rem_ff, div_ff[DIV_W-1]};
      rem_ge    = (rem_shift >= (CNT_W + 1)'(count_ff));
      rem_next  = rem_ge ? CNT_W'(rem_shift - (CNT_W + 1)'(count_ff)) : CNT_W'(rem_shift);
      div_next  = {div_ff[DIV_W-2:0], rem_ge};
      div_done  = (step_ff == STEP_W'(DIV_W - 1));
      sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   end

   assign cx_last = (cx_ff == nx_ff - 1'b1);
   assign ry_last = (ry_ff == ny_ff - 1'b1);
   assign rd_addr = addr_ff;

   // Sequencer: next state and strobes.
   always_comb begin
      state_in    = state_ff;
      q_pop       = 1'b0;
      rd_en       = 1'b0;
      addr_in     = addr_ff;
      row_addr_in = row_addr_ff;
      cx_in       = cx_ff;
      ry_in       = ry_ff;
      div_in      = div_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = BK_SETUP;
            end
         end
         BK_SETUP: begin
            addr_in     = base;
            row_addr_in = base;
            cx_in       = '0;
            ry_in       = '0;
            state_in    = BK_SCAN;
         end
         BK_SCAN: begin
            rd_en = 1'b1;
            if (cx_last) begin
               cx_in       = '0;
               ry_in       = ry_ff + 1'b1;
               row_addr_in = addr_add(row_addr_ff, frame.width);
               addr_in     = row_addr_in;
               if (ry_last) state_in = BK_FLUSH;
            end else begin
               cx_in   = cx_ff + 1'b1;
               addr_in = addr_inc(addr_ff);
            end
         end
         BK_FLUSH: begin
            if (!v1_ff && !v2_ff) begin
               div_in   = sumsq_ff;
               rem_in   = '0;
               step_in  = '0;
               state_in = BK_DIV_SQ;
            end
         end
         BK_DIV_SQ: begin
            div_in  = div_next;
            rem_in  = rem_next;
            step_in = step_ff + 1'b1;
            if (div_done) begin
               div_in   = DIV_W'(sum_mag);
               rem_in   = '0;
               step_in  = '0;
               state_in = BK_DIV_SUM;
            end
         end
         BK_DIV_SUM: begin
            div_in  = div_next;
            rem_in  = rem_next;
            step_in = step_ff + 1'b1;
            if (div_done) state_in = BK_SQUARE;
         end
         BK_SQUARE: begin
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   // Job registers, scan counters and divider.
   always_ff @(posedge clock) begin
      if (q_pop) cmd_ff <= q_head;
      if (state_ff == BK_SETUP) begin
         ny_ff    <= ny_calc;
         nx_ff    <= nx_calc;
         count_ff <= CNT_W'(ny_calc * nx_calc);
      end
      addr_ff     <= addr_in;
      row_addr_ff <= row_addr_in;
      cx_ff       <= cx_in;
      ry_ff       <= ry_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      if ((state_ff == BK_DIV_SQ) && div_done) begin
         qsq_ff <= div_next[PIX_W-1:0];
         neg_ff <= sum_ff[SUM_W-1];
      end
      if ((state_ff == BK_DIV_SUM) && div_done) begin
         mean_ff <= neg_ff ? -$signed(div_next[PIX_W-1:0]) : $signed(div_next[PIX_W-1:0]);
      end
      if (state_ff == BK_SQUARE) mm_ff <= mean_ff * mean_ff;
   end

   // Read pipeline valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
      end
   end

   // Square each sample, then accumulate sum and shifted square.
   always_ff @(posedge clock) begin
      val2_ff <= rd_data;
      sq2_ff  <= $signed(rd_data) * $signed(rd_data);
      if (state_ff == BK_SETUP) begin
         sum_ff   <= '0;
         sumsq_ff <= '0;
      end else if (v2_ff) begin
         sum_ff   <= sum_ff + $signed({{(SUM_W - PIX_W){val2_ff[PIX_W-1]}}, val2_ff});
         sumsq_ff <= sumsq_ff + SQ_W'(sq2_ff[2*PIX_W-2:FRAC_W]);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == BK_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == BK_DONE) && out_free) begin
         rsp_variance_ff   <= qsq_ff - mm_ff[PIX_W+FRAC_W-1:FRAC_W];
         rsp_frame_last_ff <= cmd_ff.last;
      end
   end

endmodule
`default_nettype wire

// File: hdl/wlv_checker.sv
// Port-level checks of the windowed local variance block and their binding.
`default_nettype none
module wlv_checker import wlv_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  req_type,
   input wire logic [PIX_W-1:0]      req_pixel_value,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [PIX_W-1:0]      rsp_variance,
   input wire logic                  rsp_frame_last,
   input wire logic                  csr_valid,
   input wire logic                  csr_ready
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its contents.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_variance) && $stable(rsp_frame_last))
      else $error("result changed while stalled");

   // A stalled request stays offered with the same contents.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_type) && $stable(req_pixel_value))
      else $error("request changed while stalled");

   // Results never come back to back: each one needs a full window pass.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("results delivered in consecutive cycles");

   // The register port never holds off a write.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write held off");

endmodule

bind windowed_local_variance wlv_checker u_wlv_checker (.*);
`default_nettype wire
